/* rtl/bba_pkg.sv */
package bba_pkg;

  // Field widths of the item ports
  localparam int unsigned ADDR_W   = 32;
  localparam int unsigned OP_W     = 2;
  localparam int unsigned REQ_W    = 21;
  localparam int unsigned BYTES_W  = 21;
  localparam int unsigned STATUS_W = 2;

  // Heap geometry
  localparam int unsigned HEAP_BLOCKS = 256;
  localparam int unsigned BLOCK_BYTES = 4096;
  localparam int unsigned BYTE_SHIFT  = $clog2(BLOCK_BYTES);
  localparam int unsigned BLK_W       = $clog2(HEAP_BLOCKS);
  localparam int unsigned CNT_W       = $clog2(HEAP_BLOCKS + 1);

  // Cell chain: each cell owns CELL_BLOCKS consecutive blocks
  localparam int unsigned CELL_BLOCKS = 8;
  localparam int unsigned LANE_W      = $clog2(CELL_BLOCKS);
  localparam int unsigned NUM_CELLS   = HEAP_BLOCKS / CELL_BLOCKS;
  localparam int unsigned CELL_W      = BLK_W - LANE_W;

  // Address arithmetic is done one bit wider so that range checks do not wrap
  localparam int unsigned XW = ADDR_W + 1;
  localparam logic [XW-1:0] SPAN_X = XW'(HEAP_BLOCKS * BLOCK_BYTES);

  typedef enum logic [OP_W-1:0] {
    OP_ALLOC = 2'd0,
    OP_FREE  = 2'd1,
    OP_QUERY = 2'd2
  } op_t;

  typedef enum logic [STATUS_W-1:0] {
    ST_OK      = 2'd0,
    ST_FAIL    = 2'd1,
    ST_IGNORED = 2'd2
  } status_t;

  // Token that walks the cell chain, one cell per cycle
  typedef struct packed {
    logic             vld;
    logic             alloc;     // search for a free run
    logic [CNT_W-1:0] need;      // run length wanted
    logic [CNT_W-1:0] run;       // free blocks seen in a row so far
    logic             found;
    logic [BLK_W-1:0] start;     // first block of the run found
    logic             clr;       // release the run at blk
    logic [BLK_W-1:0] blk;
    logic             clearing;  // inside the run being released
    logic             head_ok;   // blk was a live run start
    logic [CNT_W-1:0] cleared;   // blocks released
  } tok_t;

  // Marking of a granted run, broadcast to all cells
  typedef struct packed {
    logic             en;
    logic [BLK_W-1:0] first;
    logic [BLK_W-1:0] last;
  } commit_t;

endpackage

/* rtl/bba_if.sv */
interface bba_cmd_if;
  logic                          valid;
  logic                          ready;
  logic [bba_pkg::OP_W-1:0]      op;
  logic [bba_pkg::REQ_W-1:0]     req_bytes;
  logic [bba_pkg::ADDR_W-1:0]    free_addr;

  modport source (output valid, op, req_bytes, free_addr, input ready);
  modport sink   (input valid, op, req_bytes, free_addr, output ready);
endinterface

interface bba_rsp_if;
  logic                          valid;
  logic                          ready;
  logic [bba_pkg::STATUS_W-1:0]  status;
  logic [bba_pkg::ADDR_W-1:0]    alloc_addr;
  logic [bba_pkg::BYTES_W-1:0]   used_bytes;
  logic [bba_pkg::BYTES_W-1:0]   free_bytes;

  modport source (output valid, status, alloc_addr, used_bytes, free_bytes, input ready);
  modport sink   (input valid, status, alloc_addr, used_bytes, free_bytes, output ready);
endinterface

/* rtl/bba_cell.sv */
module bba_cell (
  input  logic                          clk,
  input  logic                          rst,
  input  logic [bba_pkg::CELL_W-1:0]    idx,
  input  bba_pkg::tok_t                 tok_in,
  input  bba_pkg::commit_t              commit,
  output bba_pkg::tok_t                 tok_out
);
  import bba_pkg::*;

  logic [CELL_BLOCKS-1:0] used;
  logic [CELL_BLOCKS-1:0] head;
  logic [CELL_BLOCKS-1:0] used_next;
  logic [CELL_BLOCKS-1:0] head_next;
  tok_t                   t;
  logic [BLK_W-1:0]       b;
  logic [CNT_W-1:0]       st_w;

  // Work the token over this cell's blocks, lowest first
  always_comb begin
    t         = tok_in;
    used_next = used;
    head_next = head;
    b         = '0;
    st_w      = '0;
    for (int j = 0; j < CELL_BLOCKS; j++) begin
      b = {idx, LANE_W'(j)};

      // first fit: count free blocks in a row until the run is long enough
      if (t.vld && t.alloc && !t.found) begin
        if (used[j]) begin
          t.run = '0;
        end else begin
          t.run = t.run + 1'b1;
        end
        if (t.run == t.need) begin
          st_w    = CNT_W'(b) + 1'b1 - t.need;
          t.found = 1'b1;
          t.start = st_w[BLK_W-1:0];
        end
      end

      // release: start at a live run head, go on over used non-head blocks
      if (t.vld && t.clr) begin
        if (b == t.blk) begin
          t.clearing = used[j] && head[j];
          t.head_ok  = t.clearing;
        end else if (t.clearing && (!used[j] || head[j])) begin
          t.clearing = 1'b0;
        end
        if (t.clearing) begin
          used_next[j] = 1'b0;
          head_next[j] = 1'b0;
          t.cleared    = t.cleared + 1'b1;
        end
      end

      // mark a granted run
      if (commit.en) begin
        if (b >= commit.first && b <= commit.last) begin
          used_next[j] = 1'b1;
        end
        if (b == commit.first) begin
          head_next[j] = 1'b1;
        end
      end
    end
  end

  // Hold block state, hand the token on
  always_ff @(posedge clk) begin
    if (rst) begin
      used        <= '0;
      head        <= '0;
      tok_out.vld <= 1'b0;
    end else begin
      used    <= used_next;
      head    <= head_next;
      tok_out <= t;
    end
  end

endmodule

/* rtl/bitmap_block_allocator.sv */
// First-fit block allocator over a heap of HEAP_BLOCKS blocks of BLOCK_BYTES bytes
// starting at heap_base. Allocate rounds the size up to whole blocks and grants the
// lowest free run that fits; free releases the run that starts at the given address;
// query and the unused op code only report usage. Every item returns one result with
// status and the used and free byte counts after the operation. One item is handled
// at a time: it enters a chain of NUM_CELLS cells, each covering eight blocks, and
// walks it at one cell per clock. It passes an entry stage, the cell chain, a capture
// stage and the result register before the next item is accepted. A new item is
// taken while the previous result still waits on rsp.
module bitmap_block_allocator (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         cfg_we,
  input  logic [bba_pkg::ADDR_W-1:0]   cfg_wdata,
  bba_cmd_if.sink                      cmd,
  bba_rsp_if.source                    rsp
);
  import bba_pkg::*;

  typedef enum logic [1:0] {
    S_IDLE,
    S_SCAN,
    S_FIN
  } state_t;

  state_t              state;
  logic [ADDR_W-1:0]   heap_base;
  logic [CNT_W-1:0]    used_count;
  logic [CNT_W-1:0]    used_next;
  logic [OP_W-1:0]     kind;
  tok_t                inj;
  tok_t                entry_tok;
  tok_t                fin;
  tok_t                chain [NUM_CELLS+1];
  logic [NUM_CELLS:0]  chain_vld;
  commit_t             commit;
  logic                out_free;
  logic                rsp_load;

  logic                rsp_valid;
  logic [STATUS_W-1:0] rsp_status;
  logic [ADDR_W-1:0]   rsp_addr;
  logic [BYTES_W-1:0]  rsp_used;
  logic [BYTES_W-1:0]  rsp_free;
  status_t             status_next;
  logic [ADDR_W-1:0]   addr_next;

  logic [XW-1:0]       req_x;
  logic [XW-1:0]       need_sum;
  logic                req_ok;
  logic [XW-1:0]       fa_x;
  logic [XW-1:0]       base_x;
  logic [XW-1:0]       off_x;
  logic                free_ok;
  logic [CNT_W-1:0]    last_w;

  // Decode the incoming item into a chain token
  always_comb begin
    req_x    = XW'(cmd.req_bytes);
    need_sum = req_x + XW'(BLOCK_BYTES - 1);
    req_ok   = (req_x != '0) && (req_x <= SPAN_X);
    fa_x     = XW'(cmd.free_addr);
    base_x   = XW'(heap_base);
    off_x    = fa_x - base_x;
    free_ok  = (fa_x >= base_x) && (fa_x < base_x + SPAN_X) &&
               (off_x[BYTE_SHIFT-1:0] == '0);

    entry_tok          = '0;
    entry_tok.vld      = 1'b1;
    entry_tok.alloc    = (cmd.op == OP_ALLOC) && req_ok;
    entry_tok.need     = CNT_W'(need_sum >> BYTE_SHIFT);
    entry_tok.clr      = (cmd.op == OP_FREE) && free_ok;
    entry_tok.blk      = off_x[BYTE_SHIFT +: BLK_W];
  end

  // Cell chain
  assign chain[0]     = inj;
  assign chain_vld[0] = inj.vld;

  for (genvar k = 0; k < NUM_CELLS; k++) begin : g_cell
    bba_cell u_cell (
      .clk     (clk),
      .rst     (rst),
      .idx     (CELL_W'(k)),
      .tok_in  (chain[k]),
      .commit  (commit),
      .tok_out (chain[k+1])
    );
    assign chain_vld[k+1] = chain[k+1].vld;
  end

  // Form the result from the finished token
  assign out_free = !rsp_valid || rsp.ready;
  assign rsp_load = (state == S_FIN) && out_free;

  always_comb begin
    status_next = ST_OK;
    addr_next   = '0;
    used_next   = used_count;
    unique case (kind)
      OP_ALLOC: begin
        if (fin.found) begin
          addr_next = heap_base + (ADDR_W'(fin.start) << BYTE_SHIFT);
          used_next = used_count + fin.need;
        end else begin
          status_next = ST_FAIL;
        end
      end
      OP_FREE: begin
        if (fin.head_ok) begin
          used_next = used_count - fin.cleared;
        end else begin
          status_next = ST_IGNORED;
        end
      end
      default: begin
        status_next = ST_OK;
      end
    endcase

    last_w       = CNT_W'(fin.start) + fin.need - 1'b1;
    commit.en    = rsp_load && (kind == OP_ALLOC) && fin.found;
    commit.first = fin.start;
    commit.last  = last_w[BLK_W-1:0];
  end

  // Control sequence and result register
  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_IDLE;
      heap_base  <= '0;
      used_count <= '0;
      inj.vld    <= 1'b0;
      rsp_valid  <= 1'b0;
    end else begin
      if (cfg_we) begin
        heap_base <= cfg_wdata;
      end
      // drop the launched token once the controller has left idle, or while no item is offered
      if (state != S_IDLE || !cmd.valid) begin
        inj.vld <= 1'b0;
      end
      // load a new result or retire the delivered one
      if (rsp_load) begin
        rsp_valid <= 1'b1;
      end else if (rsp.ready) begin
        rsp_valid <= 1'b0;
      end
      unique case (state)
        S_IDLE: begin
          if (cmd.valid) begin
            inj   <= entry_tok;
            kind  <= cmd.op;
            state <= S_SCAN;
          end
        end
        S_SCAN: begin
          if (chain[NUM_CELLS].vld) begin
            fin   <= chain[NUM_CELLS];
            state <= S_FIN;
          end
        end
        S_FIN: begin
          if (out_free) begin
            rsp_status <= status_next;
            rsp_addr   <= addr_next;
            rsp_used   <= BYTES_W'(XW'(used_next) << BYTE_SHIFT);
            rsp_free   <= BYTES_W'((XW'(HEAP_BLOCKS) - XW'(used_next)) << BYTE_SHIFT);
            used_count <= used_next;
            state      <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  assign cmd.ready      = (state == S_IDLE);
  assign rsp.valid      = rsp_valid;
  assign rsp.status     = rsp_status;
  assign rsp.alloc_addr = rsp_addr;
  assign rsp.used_bytes = rsp_used;
  assign rsp.free_bytes = rsp_free;

  // At most one item travels the chain
  a_one_token: assert property (@(posedge clk) disable iff (rst) $onehot0(chain_vld))
    else $error("more than one token in the cell chain");

  // A token leaves the chain only while the controller waits for it
  a_tail_in_scan: assert property (@(posedge clk) disable iff (rst)
    chain[NUM_CELLS].vld |-> state == S_SCAN)
    else $error("token left the chain outside the scan phase");

  // A granted run lies inside the heap
  a_run_fits: assert property (@(posedge clk) disable iff (rst)
    commit.en |-> (XW'(fin.start) + XW'(fin.need) <= XW'(HEAP_BLOCKS)) && fin.need != '0)
    else $error("granted run runs past the heap");

  // A successful free releases at least its head block
  a_free_count: assert property (@(posedge clk) disable iff (rst)
    state == S_FIN && kind == OP_FREE && fin.head_ok |-> fin.cleared != '0 &&
    fin.cleared <= used_count)
    else $error("free released an impossible block count");

  // Usage never exceeds the heap
  a_used_bound: assert property (@(posedge clk) disable iff (rst)
    XW'(used_count) <= XW'(HEAP_BLOCKS))
    else $error("used block count out of range");

endmodule

/* bench/alloc_checker.sv */
`timescale 1ns / 100ps

// Watches the request and response channels of the allocator, keeps its own
// copy of the block map, predicts each response and compares it.
module alloc_checker (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           cfg_we,
  input  logic [bba_pkg::ADDR_W-1:0]     cfg_wdata,
  bba_cmd_if                             cmd,
  bba_rsp_if                             rsp,
  output int                             errors,
  output int                             pending,
  output int                             checked,
  output logic [bba_pkg::HEAP_BLOCKS-1:0] live_heads
);
  import bba_pkg::*;

  typedef struct packed {
    status_t             status;
    logic [ADDR_W-1:0]   alloc_addr;
    logic [BYTES_W-1:0]  used_bytes;
    logic [BYTES_W-1:0]  free_bytes;
  } outcome_t;

  localparam longint unsigned HEAP_SPAN = longint'(HEAP_BLOCKS) * BLOCK_BYTES;

  // Shadow heap state
  logic [ADDR_W-1:0]      heap_base;
  logic [HEAP_BLOCKS-1:0] busy_map;
  logic [CNT_W-1:0]       run_len [HEAP_BLOCKS];
  int unsigned            used_blocks;

  outcome_t outcome_q [$];

  // Flag every block that starts a live run, for the stimulus side
  genvar g;
  for (g = 0; g < HEAP_BLOCKS; g++) begin : g_head
    assign live_heads[g] = (run_len[g] != '0);
  end

  // Take the lowest free run that is long enough
  function automatic status_t grant_run(input logic [REQ_W-1:0] req,
                                        output logic [ADDR_W-1:0] addr);
    longint unsigned need;
    int unsigned start, stop, k;
    addr = '0;
    if (req == '0 || req > HEAP_SPAN) return ST_FAIL;
    need = (longint'(req) + BLOCK_BYTES - 1) / BLOCK_BYTES;
    for (start = 0; start < HEAP_BLOCKS; start++) begin
      if (busy_map[start]) continue;
      stop = start;
      while (stop < HEAP_BLOCKS && !busy_map[stop] && (stop - start) < need) stop++;
      if ((stop - start) == need) begin
        for (k = start; k < stop; k++) busy_map[k] = 1'b1;
        run_len[start] = CNT_W'(need);
        used_blocks += 32'(need);
        addr = heap_base + ADDR_W'(start * BLOCK_BYTES);
        return ST_OK;
      end
    end
    return ST_FAIL;
  endfunction

  // Release the run that starts at addr, if there is one
  function automatic status_t release_run(input logic [ADDR_W-1:0] addr);
    longint unsigned base_x, off;
    int unsigned blk, len, k;
    base_x = heap_base;
    if (addr < base_x || addr >= base_x + HEAP_SPAN) return ST_IGNORED;
    off = addr - base_x;
    if (off % BLOCK_BYTES != 0) return ST_IGNORED;
    blk = int'(off / BLOCK_BYTES);
    len = 32'(run_len[blk]);
    if (len == 0) return ST_IGNORED;
    for (k = blk; k < HEAP_BLOCKS && (k - blk) < len; k++) begin
      if (busy_map[k]) begin
        busy_map[k] = 1'b0;
        if (used_blocks > 0) used_blocks--;
      end
    end
    run_len[blk] = '0;
    return ST_OK;
  endfunction

  // Apply one request to the shadow heap and return the response it owes
  function automatic outcome_t first_fit_step(input logic [OP_W-1:0] op,
                                              input logic [REQ_W-1:0] req,
                                              input logic [ADDR_W-1:0] addr);
    outcome_t res;
    logic [ADDR_W-1:0] granted;
    int unsigned used;
    granted = '0;
    res.status = ST_OK;
    if (op == OP_ALLOC) res.status = grant_run(req, granted);
    else if (op == OP_FREE) res.status = release_run(addr);
    used = (used_blocks > HEAP_BLOCKS) ? HEAP_BLOCKS : used_blocks;
    res.alloc_addr = granted;
    res.used_bytes = BYTES_W'(used * BLOCK_BYTES);
    res.free_bytes = BYTES_W'((HEAP_BLOCKS - used) * BLOCK_BYTES);
    return res;
  endfunction

  task automatic check_field(input string name, input logic [ADDR_W-1:0] want_v,
                             input logic [ADDR_W-1:0] got_v);
    if (want_v !== got_v) begin
      errors++;
      $display("%0t: %s mismatch: expected 0x%0h, got 0x%0h", $time, name, want_v, got_v);
    end
  endtask

  always @(posedge clk) begin
    outcome_t want;
    if (rst) begin
      heap_base = '0;
      busy_map = '0;
      foreach (run_len[i]) run_len[i] = '0;
      used_blocks = 0;
      outcome_q.delete();
      errors = 0;
      checked = 0;
      pending = 0;
    end else begin
      if (cfg_we) heap_base = cfg_wdata;

      // Compare a delivered response with the oldest prediction
      if (rsp.valid && rsp.ready) begin
        if (outcome_q.size() == 0) begin
          errors++;
          $display("%0t: response with none expected: status %0d addr 0x%0h used %0d free %0d",
                   $time, rsp.status, rsp.alloc_addr, rsp.used_bytes, rsp.free_bytes);
        end else begin
          want = outcome_q.pop_front();
          check_field("status", ADDR_W'(want.status), ADDR_W'(rsp.status));
          check_field("alloc_addr", want.alloc_addr, rsp.alloc_addr);
          check_field("used_bytes", ADDR_W'(want.used_bytes), ADDR_W'(rsp.used_bytes));
          check_field("free_bytes", ADDR_W'(want.free_bytes), ADDR_W'(rsp.free_bytes));
          checked++;
        end
      end

      // Predict the response of an accepted request
      if (cmd.valid && cmd.ready)
        outcome_q.push_back(first_fit_step(cmd.op, cmd.req_bytes, cmd.free_addr));

      pending = outcome_q.size();
    end
  end

endmodule

/* bench/tb.sv */
`timescale 1ns / 100ps

module tb;
  import bba_pkg::*;

  localparam logic [OP_W-1:0]  OP_SPARE  = 2'd3;
  localparam int unsigned      HEAP_SPAN = HEAP_BLOCKS * BLOCK_BYTES;
  localparam int unsigned      NUM_PHASES = 6;
  localparam int unsigned      PHASE_ITEMS = 340;
  localparam int unsigned      DRAIN_CYCLES = 40;

  logic              clk = 1'b0;
  logic              rst;
  logic              cfg_we;
  logic [ADDR_W-1:0] cfg_wdata;

  bba_cmd_if cmd ();
  bba_rsp_if rsp ();

  int                     errors, pending, checked;
  logic [HEAP_BLOCKS-1:0] live_heads;
  logic [ADDR_W-1:0]      base_now;
  bit                     steady;
  int                     n_alloc, n_free, n_query, n_bases;

  bitmap_block_allocator dut (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata),
    .cmd       (cmd),
    .rsp       (rsp)
  );

  alloc_checker u_check (
    .clk        (clk),
    .rst        (rst),
    .cfg_we     (cfg_we),
    .cfg_wdata  (cfg_wdata),
    .cmd        (cmd),
    .rsp        (rsp),
    .errors     (errors),
    .pending    (pending),
    .checked    (checked),
    .live_heads (live_heads)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  // Mostly short gaps, now and then a long one
  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  // Present one item, hold it until accepted
  task automatic send_item(input logic [OP_W-1:0] op, input logic [REQ_W-1:0] req,
                           input logic [ADDR_W-1:0] addr);
    int gap;
    gap = steady ? 0 : pick_gap();
    if (gap > 0) begin
      @(negedge clk);
      cmd.valid <= 1'b0;
      repeat (gap - 1) @(negedge clk);
    end
    @(negedge clk);
    cmd.valid     <= 1'b1;
    cmd.op        <= op;
    cmd.req_bytes <= req;
    cmd.free_addr <= addr;
    do @(posedge clk); while (!cmd.ready);
    if (op == OP_ALLOC) n_alloc++;
    else if (op == OP_FREE) n_free++;
    else n_query++;
  endtask

  // Drop valid and wait for every outstanding response
  task automatic drain();
    @(negedge clk);
    cmd.valid <= 1'b0;
    wait (pending == 0);
  endtask

  task automatic set_base(input logic [ADDR_W-1:0] value);
    @(negedge clk);
    cfg_we    <= 1'b1;
    cfg_wdata <= value;
    @(negedge clk);
    cfg_we    <= 1'b0;
    base_now = value;
    n_bases++;
  endtask

  // Build one random request, mostly frees of live runs and modest allocations
  task automatic random_request();
    logic [OP_W-1:0]   op;
    logic [REQ_W-1:0]  req;
    logic [ADDR_W-1:0] addr;
    int r, s, k, j;
    r = $urandom_range(0, 99);
    s = $urandom_range(0, 99);
    req = REQ_W'($urandom);
    addr = $urandom;
    if (r < 45) begin
      op = OP_ALLOC;
      if (s < 70) req = REQ_W'($urandom_range(1, 8 * BLOCK_BYTES));
      else if (s < 85) req = REQ_W'($urandom_range(1, HEAP_SPAN));
      else if (s < 90) req = REQ_W'($urandom_range(1, 16) * BLOCK_BYTES);
      else if (s < 94) req = '0;
      else if (s < 97) req = REQ_W'($urandom_range(HEAP_SPAN + 1, (1 << REQ_W) - 1));
      else req = REQ_W'(HEAP_SPAN);
    end else if (r < 85) begin
      op = OP_FREE;
      if (s < 65 && live_heads != '0) begin
        k = $urandom_range(0, HEAP_BLOCKS - 1);
        for (j = 0; j < HEAP_BLOCKS && !live_heads[(k + j) % HEAP_BLOCKS]; j++) begin
        end
        addr = base_now + ADDR_W'(((k + j) % HEAP_BLOCKS) * BLOCK_BYTES);
      end else if (s < 80) begin
        addr = base_now + ADDR_W'($urandom_range(0, HEAP_BLOCKS - 1) * BLOCK_BYTES);
      end else if (s < 88) begin
        addr = base_now + ADDR_W'($urandom_range(0, HEAP_SPAN - 1));
      end else if (s < 94) begin
        addr = base_now - ADDR_W'($urandom_range(1, 16 * BLOCK_BYTES));
      end else if (s < 97) begin
        addr = base_now + ADDR_W'(HEAP_SPAN + $urandom_range(0, 4 * BLOCK_BYTES));
      end
    end else if (r < 95) begin
      op = OP_QUERY;
    end else begin
      op = OP_SPARE;
    end
    send_item(op, req, addr);
  endtask

  // Response side: random stalls unless in a steady stretch
  initial begin : rsp_sink
    int hold, stall;
    rsp.ready = 1'b0;
    @(negedge clk);
    forever begin
      hold = $urandom_range(1, 12);
      rsp.ready <= 1'b1;
      repeat (hold) @(negedge clk);
      stall = steady ? 0 : pick_gap();
      if (stall > 0) begin
        rsp.ready <= 1'b0;
        repeat (stall) @(negedge clk);
      end
    end
  end

  initial begin
    #4_000_000;
    $display("[bitmap_block_allocator] ERROR");
    $finish;
  end

  initial begin : stimulus
    logic [ADDR_W-1:0] next_base;
    int p, i;
    rst = 1'b1;
    cfg_we = 1'b0;
    cfg_wdata = '0;
    cmd.valid = 1'b0;
    cmd.op = OP_QUERY;
    cmd.req_bytes = '0;
    cmd.free_addr = '0;
    base_now = '0;
    steady = 1'b0;
    n_alloc = 0;
    n_free = 0;
    n_query = 0;
    n_bases = 0;
    repeat (4) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // Directed: sizes, bad frees and a full heap at base zero
    set_base('0);
    send_item(OP_QUERY, '0, '0);
    send_item(OP_SPARE, '1, '1);
    send_item(OP_ALLOC, '0, '0);                          // zero size
    send_item(OP_ALLOC, REQ_W'(HEAP_SPAN + 1), '0);       // just over the heap
    send_item(OP_ALLOC, '1, '1);                          // largest field value
    send_item(OP_ALLOC, 21'd1, '0);                       // block 0
    send_item(OP_ALLOC, REQ_W'(BLOCK_BYTES), '0);         // block 1
    send_item(OP_ALLOC, REQ_W'(BLOCK_BYTES + 1), '0);     // blocks 2 and 3
    send_item(OP_FREE, '0, ADDR_W'(2 * BLOCK_BYTES + 1)); // unaligned
    send_item(OP_FREE, '0, ADDR_W'(3 * BLOCK_BYTES));     // inside a run
    send_item(OP_FREE, '0, ADDR_W'(5 * BLOCK_BYTES));     // never allocated
    send_item(OP_FREE, '0, ADDR_W'(HEAP_SPAN));           // first address past the heap
    send_item(OP_FREE, '0, '1);
    send_item(OP_FREE, '0, ADDR_W'(BLOCK_BYTES));
    send_item(OP_FREE, '0, ADDR_W'(BLOCK_BYTES));         // already freed
    send_item(OP_ALLOC, REQ_W'(HEAP_SPAN), '0);           // no run fits
    send_item(OP_FREE, '0, '0);                           // address zero is ordinary
    send_item(OP_FREE, '0, ADDR_W'(2 * BLOCK_BYTES));
    send_item(OP_ALLOC, REQ_W'(HEAP_SPAN), '0);           // whole heap
    send_item(OP_ALLOC, 21'd1, '0);                       // heap full
    send_item(OP_FREE, '0, '0);

    // Directed: granted addresses wrap past the top of the address space
    drain();
    set_base(32'hFFFF_F000);
    send_item(OP_ALLOC, REQ_W'(2 * BLOCK_BYTES), '0);
    send_item(OP_ALLOC, 21'd1, '0);
    send_item(OP_FREE, '0, ADDR_W'(BLOCK_BYTES));         // wrapped address is below base
    send_item(OP_FREE, '0, 32'hFFFF_F000);

    // Random phases, one heap base each
    for (p = 0; p < NUM_PHASES; p++) begin
      case (p)
        0: next_base = '0;
        1: next_base = '1;
        2: next_base = $urandom;
        3: next_base = $urandom & ~ADDR_W'(BLOCK_BYTES - 1);
        4: next_base = 32'h8000_0000;
        default: next_base = $urandom;
      endcase
      drain();
      set_base(next_base);
      for (i = 0; i < PHASE_ITEMS; i++) begin
        if (i % 50 == 0) steady = ($urandom_range(0, 3) == 0);
        if ($urandom_range(0, 99) == 0) drain();
        random_request();
      end
    end
    steady = 1'b0;

    drain();
    repeat (DRAIN_CYCLES) @(posedge clk);
    $display("Sent %0d requests (%0d allocate, %0d free, %0d usage) over %0d heap bases.",
             n_alloc + n_free + n_query, n_alloc, n_free, n_query, n_bases);
    $display("Compared %0d responses against the first-fit prediction.", checked);
    if (errors == 0) begin
      $display("[bitmap_block_allocator] OK");
    end else begin
      $display("[bitmap_block_allocator] ERROR");
    end
    $finish;
  end

endmodule

/* filelist.f */
rtl/bba_pkg.sv
rtl/bba_if.sv
rtl/bba_cell.sv
rtl/bitmap_block_allocator.sv
bench/alloc_checker.sv
bench/tb.sv
